>>> hw/rtl/u32dec_pkg.sv
`default_nettype none

package u32dec_pkg;

   // byte order codes, as held in the order register
   typedef enum logic [1:0] {
      ORDER_NONE   = 2'd0,
      ORDER_BIG    = 2'd1,
      ORDER_LITTLE = 2'd2
   } order_type;

   // what one decoded word turns into
   typedef enum logic [1:0] {
      KIND_UNIT  = 2'd0,
      KIND_PAIR  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // queue entry: single unit in value[15:0], or pair offset (code - 0x10000)
   typedef struct packed {
      kind_type    kind;
      logic [19:0] value;
   } entry_type;

   localparam logic [31:0] MARK_BIG      = 32'h0000_FEFF;
   localparam logic [31:0] MARK_LITTLE   = 32'hFFFE_0000;
   localparam logic [1:0]  LAST_BYTE     = 2'd3;
   localparam logic [20:0] PAIR_BASE     = 21'h10000;
   localparam logic [4:0]  PLANE_MAX     = 5'h10;
   localparam logic [5:0]  HIGH_PREFIX   = 6'b110110;
   localparam logic [5:0]  LOW_PREFIX    = 6'b110111;
   localparam logic [1:0]  ORDER_UNUSED  = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/u32dec_ifs.sv
`default_nettype none

interface u32dec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       restart;
   modport source (output valid, output byte_value, output restart, input ready);
   modport sink   (input valid, input byte_value, input restart, output ready);
endinterface

interface u32dec_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        status;
   logic        last_of_word;
   modport source (output valid, output code_unit, output status, output last_of_word,
                   input ready);
   modport sink   (input valid, input code_unit, input status, input last_of_word,
                   output ready);
endinterface

interface u32dec_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] expected_order;
   modport source (output valid, output expected_order, input ready);
   modport sink   (input valid, input expected_order, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/utf32_to_utf16_decoder_core.sv
// channel   dir  handshake           word contents
// req_ch    in   valid/ready         byte_value[7:0], restart
// rsp_ch    out  valid/ready         code_unit[15:0], status, last_of_word
// csr_ch    in   valid/ready (ready  expected_order[1:0]
//                always high)
//
// Cycles: one byte per cycle in; one result per cycle out while rsp_ch.ready is
// high. A word leaves the front in the cycle its fourth byte is taken, then
// passes a queue slot and the output register. A surrogate pair leaves as two
// results from the single output register. Reset: synchronous, active high;
// clears order detection, the byte gatherer, the queue and the output valid.
// Stalls: req_ch.ready drops only while the QUEUE_DEPTH entry queue is full.
`default_nettype none

module utf32_to_utf16_decoder_core
   import u32dec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   u32dec_req_if.sink   req_ch,
   u32dec_rsp_if.source rsp_ch,
   u32dec_csr_if.sink   csr_ch
);

   entry_type front_entry;
   entry_type head_entry;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;

   // gather bytes, detect the mark, classify each word
   u32dec_front front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .csr     (csr_ch),
      .q_full  (q_full),
      .q_entry (front_entry),
      .q_push  (q_push)
   );

   // decouple the classifier from the result side
   u32dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head_entry),
      .empty      (q_empty)
   );

   // expand entries into one or two UTF-16 results
   u32dec_back back (
      .clock (clock),
      .reset (reset),
      .head  (head_entry),
      .empty (q_empty),
      .pop   (q_pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

>>> hw/rtl/u32dec_front.sv
`default_nettype none

module u32dec_front
   import u32dec_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   u32dec_req_if.sink  req,
   u32dec_csr_if.sink  csr,
   input  wire logic   q_full,
   output entry_type   q_entry,
   output logic        q_push
);

   logic [1:0]  expected_ff;
   logic [23:0] gath_ff, gath_in;
   logic [1:0]  cnt_ff, cnt_in;
   order_type   act_ff, act_in;

   logic [23:0] gath_eff;
   logic [1:0]  cnt_eff;
   order_type   act_eff;
   order_type   exp_ord;
   logic [31:0] word;
   logic [31:0] code;
   logic [19:0] off;
   logic        accept;

   assign req.ready = !q_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   always_comb begin
      // restart drops the partial word and the detected order first
      gath_eff = req.restart ? 24'd0 : gath_ff;
      cnt_eff  = req.restart ? 2'd0 : cnt_ff;
      act_eff  = req.restart ? ORDER_NONE : act_ff;
      exp_ord  = (expected_ff == ORDER_UNUSED) ? ORDER_NONE : order_type'(expected_ff);
      word     = {gath_eff, req.byte_value};
      gath_in  = gath_ff;
      cnt_in   = cnt_ff;
      act_in   = act_ff;
      q_push   = 1'b0;
      code     = word;
      off      = 20'd0;
      q_entry  = '{kind: KIND_ERROR, value: 20'd0};
      if (accept) begin
         act_in = act_eff;
         if (cnt_eff != LAST_BYTE) begin
            gath_in = {gath_eff[15:0], req.byte_value};
            cnt_in  = cnt_eff + 2'd1;
         end else begin
            gath_in = 24'd0;
            cnt_in  = 2'd0;
            q_push  = 1'b1;
            if (act_eff == ORDER_NONE) begin
               if (word == MARK_BIG && exp_ord != ORDER_LITTLE) begin
                  act_in = ORDER_BIG;
                  q_push = 1'b0;
               end else if (word == MARK_LITTLE && exp_ord != ORDER_BIG) begin
                  act_in = ORDER_LITTLE;
                  q_push = 1'b0;
               end else begin
                  act_in = (exp_ord == ORDER_NONE) ? ORDER_BIG : exp_ord;
               end
            end
            code = (act_in == ORDER_BIG) ? word :
                   {word[7:0], word[15:8], word[23:16], word[31:24]};
            off  = 20'(code[20:0] - PAIR_BASE);
            if (code[31:16] == 16'd0) begin
               q_entry = '{kind: KIND_UNIT, value: {4'd0, code[15:0]}};
            end else if (code[31:21] == 11'd0 && code[20:16] <= PLANE_MAX) begin
               q_entry = '{kind: KIND_PAIR, value: off};
            end else begin
               q_entry = '{kind: KIND_ERROR, value: 20'd0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= ORDER_NONE;
         gath_ff     <= 24'd0;
         cnt_ff      <= 2'd0;
         act_ff      <= ORDER_NONE;
      end else begin
         if (csr.valid) begin
            expected_ff <= csr.expected_order;
         end
         gath_ff <= gath_in;
         cnt_ff  <= cnt_in;
         act_ff  <= act_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/u32dec_queue.sv
`default_nettype none

module u32dec_queue
   import u32dec_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      head,
   output logic           empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   entry_type     slots_ff [DEPTH];
   logic [AW-1:0] wptr_ff, rptr_ff;
   logic [CW-1:0] cnt_ff;
   logic          do_push, do_pop;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == LAST_SLOT) ? '0 : wptr_ff + AW'(1);
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == LAST_SLOT) ? '0 : rptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/u32dec_back.sv
`default_nettype none

module u32dec_back
   import u32dec_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire entry_type head,
   input  wire logic      empty,
   output logic           pop,
   u32dec_rsp_if.source   rsp
);

   logic        out_valid_ff, out_valid_in;
   logic [15:0] unit_ff, unit_in;
   logic        status_ff, status_in;
   logic        last_ff, last_in;
   logic        pend_ff, pend_in;
   logic [9:0]  low_ff, low_in;
   logic        load;

   assign rsp.valid        = out_valid_ff;
   assign rsp.code_unit    = unit_ff;
   assign rsp.status       = status_ff;
   assign rsp.last_of_word = last_ff;

   assign load = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      unit_in      = unit_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      low_in       = low_ff;
      pop          = 1'b0;
      if (load) begin
         if (pend_ff) begin
            // second half of a surrogate pair
            out_valid_in = 1'b1;
            unit_in      = {LOW_PREFIX, low_ff};
            status_in    = 1'b0;
            last_in      = 1'b1;
            pend_in      = 1'b0;
         end else if (!empty) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            case (head.kind)
               KIND_UNIT: begin
                  unit_in   = head.value[15:0];
                  status_in = 1'b0;
                  last_in   = 1'b1;
               end
               KIND_PAIR: begin
                  unit_in   = {HIGH_PREFIX, head.value[19:10]};
                  status_in = 1'b0;
                  last_in   = 1'b0;
                  pend_in   = 1'b1;
                  low_in    = head.value[9:0];
               end
               default: begin
                  unit_in   = 16'd0;
                  status_in = 1'b1;
                  last_in   = 1'b1;
               end
            endcase
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      unit_ff   <= unit_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      low_ff    <= low_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/u32dec_checker.sv
`default_nettype none

module u32dec_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_code_unit,
   input wire logic        rsp_status,
   input wire logic        rsp_last
);

   // an error word carries a zero unit and closes its word
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_code_unit == 16'd0 && rsp_last)
      else $error("error result with nonzero unit or open word");

   // only a high surrogate leaves a word open
   a_open_is_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_status && rsp_code_unit[15:10] == 6'b110110)
      else $error("open word without high surrogate");

   // the low half follows right after the high half is taken
   a_low_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_last && !rsp_status && rsp_code_unit[15:10] == 6'b110111)
      else $error("low surrogate missing after high surrogate");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_unit))
      else $error("stalled result changed");

endmodule

bind utf32_to_utf16_decoder_core u32dec_checker checker_inst (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_code_unit (rsp_ch.code_unit),
   .rsp_status    (rsp_ch.status),
   .rsp_last      (rsp_ch.last_of_word)
);

`default_nettype wire
